/* rtl/gic_pkg.sv */
package gic_pkg;

    localparam int MODE_W   = 2;
    localparam int NODE_W   = 11;
    localparam int WEIGHT_W = 32;
    localparam int KIND_W   = 2;
    localparam int KEPT_W   = 13;
    localparam int ERR_W    = 2;
    localparam int DEG_W    = 14;

    localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FINISH = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DRAIN  = 2'd2;

    localparam logic [KIND_W-1:0] KIND_TOTALS = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EDGE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REJECT = 2'd2;

    localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
    localparam logic [ERR_W-1:0] ERR_RANGE = 2'd1;
    localparam logic [ERR_W-1:0] ERR_FULL  = 2'd2;

    localparam logic [DEG_W-1:0] DEG_MAX = '1;

    typedef struct packed {
        logic [KIND_W-1:0]          kind;
        logic [NODE_W-1:0]          first_node;
        logic [NODE_W-1:0]          second_node;
        logic signed [WEIGHT_W-1:0] edge_weight;
        logic [KEPT_W-1:0]          kept_edges;
        logic                       last_edge;
        logic [ERR_W-1:0]           error_code;
    } t_result;

    typedef struct packed {
        logic deg_re;
        logic deg_we;
        logic lab_re;
        logic lab_we;
    } t_node_ctl;

    function automatic logic [DEG_W-1:0] deg_inc(input logic [DEG_W-1:0] d);
        return (d == DEG_MAX) ? d : d + DEG_W'(1);
    endfunction

endpackage

/* rtl/gic_if.sv */
interface gic_cfg_if;
    import gic_pkg::*;
    logic              valid;
    logic              ready;
    logic [NODE_W-1:0] node_count;
    modport source (output valid, output node_count, input ready);
    modport sink (input valid, input node_count, output ready);
endinterface

interface gic_in_if;
    import gic_pkg::*;
    logic                       valid;
    logic                       ready;
    logic [MODE_W-1:0]          mode;
    logic [NODE_W-1:0]          src_node;
    logic [NODE_W-1:0]          dst_node;
    logic signed [WEIGHT_W-1:0] weight;
    modport source (output valid, output mode, output src_node, output dst_node,
                    output weight, input ready);
    modport sink (input valid, input mode, input src_node, input dst_node,
                  input weight, output ready);
endinterface

interface gic_out_if;
    import gic_pkg::*;
    logic                       valid;
    logic                       ready;
    logic [KIND_W-1:0]          kind;
    logic [NODE_W-1:0]          first_node;
    logic [NODE_W-1:0]          second_node;
    logic signed [WEIGHT_W-1:0] edge_weight;
    logic [KEPT_W-1:0]          kept_edges;
    logic                       last_edge;
    logic [ERR_W-1:0]           error_code;
    modport source (output valid, output kind, output first_node, output second_node,
                    output edge_weight, output kept_edges, output last_edge,
                    output error_code, input ready);
    modport sink (input valid, input kind, input first_node, input second_node,
                  input edge_weight, input kept_edges, input last_edge,
                  input error_code, output ready);
endinterface

/* rtl/gic_node_store.sv */
module gic_node_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                      i_clk,
    input  gic_pkg::t_node_ctl        i_ctl,
    input  logic [AW-1:0]             i_deg_raddr,
    input  logic [AW-1:0]             i_deg_waddr,
    input  logic [gic_pkg::DEG_W-1:0] i_deg_wdata,
    output logic [gic_pkg::DEG_W-1:0] o_deg_rdata,
    input  logic [AW-1:0]             i_lab_waddr,
    input  logic [AW-1:0]             i_lab_wdata,
    input  logic [AW-1:0]             i_lab_raddr_a,
    input  logic [AW-1:0]             i_lab_raddr_b,
    output logic [AW-1:0]             o_lab_rdata_a,
    output logic [AW-1:0]             o_lab_rdata_b
);
    import gic_pkg::*;

    logic [DEG_W-1:0] r_deg_mem [DEPTH];
    logic [AW-1:0]    r_lab_mem [DEPTH];
    logic [DEG_W-1:0] r_deg_rdata;
    logic [AW-1:0]    r_lab_rdata_a;
    logic [AW-1:0]    r_lab_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_ctl.deg_we) begin
            r_deg_mem[i_deg_waddr] <= i_deg_wdata;
        end
        if (i_ctl.deg_re) begin
            r_deg_rdata <= r_deg_mem[i_deg_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.lab_we) begin
            r_lab_mem[i_lab_waddr] <= i_lab_wdata;
        end
        if (i_ctl.lab_re) begin
            r_lab_rdata_a <= r_lab_mem[i_lab_raddr_a];
            r_lab_rdata_b <= r_lab_mem[i_lab_raddr_b];
        end
    end

    assign o_deg_rdata   = r_deg_rdata;
    assign o_lab_rdata_a = r_lab_rdata_a;
    assign o_lab_rdata_b = r_lab_rdata_b;

endmodule

/* rtl/gic_edge_store.sv */
module gic_edge_store #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int DW    = 52
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/graph_isolated_node_compactor.sv */
// graph_isolated_node_compactor
// channels: i_cfg writes node_count (always ready), i_in carries items, o_out results.
// items are taken one at a time; i_in.ready is high only while no item is in work.
// load: two read-modify-write passes on the degree store, which has one read port;
//   zero weight edges, wrong-phase items and unused-mode items give no result.
// rejected load: the registered result moves to the output register once it is free.
// finish: one degree entry read per cycle in node order, then the totals result.
// drain: edge store read, then two label reads, then the result.
// results go through one output register; a stalled receiver holds it while
// the next item is already accepted, and only a later result waits on it.
// reset: a clearing pass zeroes every degree store entry in turn, no item is
// accepted meanwhile; configuration writes are taken throughout.
// after the last drained edge the edge store empties and loading starts again.
module graph_isolated_node_compactor #(
    parameter int MAX_NODES = 1024,
    parameter int MAX_EDGES = 4096
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gic_cfg_if.sink    i_cfg,
    gic_in_if.sink     i_in,
    gic_out_if.source  o_out
);
    import gic_pkg::*;

    localparam int NW  = $clog2(MAX_NODES);
    localparam int CW  = NW + 1;
    localparam int EW  = $clog2(MAX_EDGES + 1);
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ERW = 2 * NW + WEIGHT_W;

    localparam logic [3:0] S_CLR     = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_LD_A    = 4'd2;
    localparam logic [3:0] S_LD_B    = 4'd3;
    localparam logic [3:0] S_FIN     = 4'd4;
    localparam logic [3:0] S_FIN_END = 4'd5;
    localparam logic [3:0] S_DR_E    = 4'd6;
    localparam logic [3:0] S_DR_L    = 4'd7;
    localparam logic [3:0] S_EMIT    = 4'd8;

    logic [3:0]        r_state, n_state;
    logic [CW-1:0]     r_scan, n_scan;
    logic              r_chk, n_chk;
    logic [NW-1:0]     r_chk_addr, n_chk_addr;
    logic [CW-1:0]     r_node_total, n_node_total;
    logic [EW-1:0]     r_edge_total, n_edge_total;
    logic [EW-1:0]     r_drain_ptr, n_drain_ptr;
    logic              r_draining, n_draining;
    logic [NODE_W-1:0] r_node_count, n_node_count;
    logic [NW-1:0]     r_src_idx, n_src_idx;
    logic [NW-1:0]     r_dst_idx, n_dst_idx;
    logic [DEG_W-1:0]  r_deg_fwd, n_deg_fwd;
    t_result           r_res, n_res;
    logic              r_out_valid, n_out_valid;
    t_result           r_out, n_out;

    t_node_ctl        node_ctl;
    logic [NW-1:0]    deg_raddr, deg_waddr;
    logic [DEG_W-1:0] deg_wdata, deg_rdata, deg_val;
    logic [NW-1:0]    lab_waddr, lab_wdata;
    logic [NW-1:0]    lab_raddr_a, lab_raddr_b;
    logic [NW-1:0]    lab_a, lab_b, lab_lo, lab_hi;

    logic             edge_we, edge_re;
    logic [EAW-1:0]   edge_waddr, edge_raddr;
    logic [ERW-1:0]   edge_wdata, edge_rdata;

    logic             out_free;
    logic             src_ok, dst_ok, edge_room, drain_last;
    logic [NW-1:0]    src_idx, dst_idx;

    gic_node_store #(
        .DEPTH (MAX_NODES),
        .AW    (NW)
    ) u_node_store (
        .i_clk         (i_clk),
        .i_ctl         (node_ctl),
        .i_deg_raddr   (deg_raddr),
        .i_deg_waddr   (deg_waddr),
        .i_deg_wdata   (deg_wdata),
        .o_deg_rdata   (deg_rdata),
        .i_lab_waddr   (lab_waddr),
        .i_lab_wdata   (lab_wdata),
        .i_lab_raddr_a (lab_raddr_a),
        .i_lab_raddr_b (lab_raddr_b),
        .o_lab_rdata_a (lab_a),
        .o_lab_rdata_b (lab_b)
    );

    gic_edge_store #(
        .DEPTH (MAX_EDGES),
        .AW    (EAW),
        .DW    (ERW)
    ) u_edge_store (
        .i_clk   (i_clk),
        .i_we    (edge_we),
        .i_waddr (edge_waddr),
        .i_wdata (edge_wdata),
        .i_re    (edge_re),
        .i_raddr (edge_raddr),
        .o_rdata (edge_rdata)
    );

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == S_IDLE);
    assign out_free    = !r_out_valid || o_out.ready;

    assign src_ok = (i_in.src_node != '0) && (i_in.src_node <= r_node_count)
                    && (32'(i_in.src_node) <= 32'(MAX_NODES));
    assign dst_ok = (i_in.dst_node != '0) && (i_in.dst_node <= r_node_count)
                    && (32'(i_in.dst_node) <= 32'(MAX_NODES));
    assign src_idx    = NW'(i_in.src_node - NODE_W'(1));
    assign dst_idx    = NW'(i_in.dst_node - NODE_W'(1));
    assign edge_room  = r_edge_total < EW'(MAX_EDGES);
    assign drain_last = (EW'(r_drain_ptr + EW'(1)) == r_edge_total);
    assign deg_val    = (r_dst_idx == r_src_idx) ? r_deg_fwd : deg_rdata;
    assign lab_lo     = (lab_a > lab_b) ? lab_b : lab_a;
    assign lab_hi     = (lab_a > lab_b) ? lab_a : lab_b;

    always_comb begin
        n_state      = r_state;
        n_scan       = r_scan;
        n_chk        = r_chk;
        n_chk_addr   = r_chk_addr;
        n_node_total = r_node_total;
        n_edge_total = r_edge_total;
        n_drain_ptr  = r_drain_ptr;
        n_draining   = r_draining;
        n_node_count = r_node_count;
        n_src_idx    = r_src_idx;
        n_dst_idx    = r_dst_idx;
        n_deg_fwd    = r_deg_fwd;
        n_res        = r_res;
        n_out_valid  = r_out_valid;
        n_out        = r_out;

        node_ctl    = '0;
        deg_raddr   = r_scan[NW-1:0];
        deg_waddr   = r_chk_addr;
        deg_wdata   = '0;
        lab_waddr   = r_chk_addr;
        lab_wdata   = r_node_total[NW-1:0];
        lab_raddr_a = edge_rdata[ERW-1 -: NW];
        lab_raddr_b = edge_rdata[WEIGHT_W +: NW];
        edge_we     = 1'b0;
        edge_re     = 1'b0;
        edge_waddr  = r_edge_total[EAW-1:0];
        edge_raddr  = r_drain_ptr[EAW-1:0];
        edge_wdata  = {src_idx, dst_idx, i_in.weight};

        if (i_cfg.valid) begin
            n_node_count = i_cfg.node_count;
        end

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLR: begin
                node_ctl.deg_we = 1'b1;
                deg_waddr       = r_scan[NW-1:0];
                n_scan          = r_scan + CW'(1);
                if (r_scan == CW'(MAX_NODES - 1)) begin
                    n_scan  = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in.valid) begin
                    case (i_in.mode)
                        MODE_LOAD: begin
                            if (!r_draining && i_in.weight != '0) begin
                                n_res = '0;
                                n_res.kept_edges = KEPT_W'(r_edge_total);
                                if (!(src_ok && dst_ok)) begin
                                    n_res.kind       = KIND_REJECT;
                                    n_res.error_code = ERR_RANGE;
                                    n_state          = S_EMIT;
                                end else if (!edge_room) begin
                                    n_res.kind       = KIND_REJECT;
                                    n_res.error_code = ERR_FULL;
                                    n_state          = S_EMIT;
                                end else begin
                                    edge_we         = 1'b1;
                                    n_edge_total    = r_edge_total + EW'(1);
                                    node_ctl.deg_re = 1'b1;
                                    deg_raddr       = src_idx;
                                    n_src_idx       = src_idx;
                                    n_dst_idx       = dst_idx;
                                    n_state         = S_LD_A;
                                end
                            end
                        end
                        MODE_FINISH: begin
                            if (!r_draining) begin
                                n_scan       = '0;
                                n_chk        = 1'b0;
                                n_node_total = '0;
                                n_state      = S_FIN;
                            end
                        end
                        MODE_DRAIN: begin
                            if (r_draining && r_drain_ptr < r_edge_total) begin
                                edge_re = 1'b1;
                                n_state = S_DR_E;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_LD_A: begin
                node_ctl.deg_we = 1'b1;
                deg_waddr       = r_src_idx;
                deg_wdata       = deg_inc(deg_rdata);
                n_deg_fwd       = deg_inc(deg_rdata);
                node_ctl.deg_re = 1'b1;
                deg_raddr       = r_dst_idx;
                n_state         = S_LD_B;
            end
            S_LD_B: begin
                node_ctl.deg_we = 1'b1;
                deg_waddr       = r_dst_idx;
                deg_wdata       = deg_inc(deg_val);
                n_state         = S_IDLE;
            end
            S_FIN: begin
                if (r_scan != CW'(MAX_NODES)) begin
                    node_ctl.deg_re = 1'b1;
                    n_scan          = r_scan + CW'(1);
                    n_chk           = 1'b1;
                    n_chk_addr      = r_scan[NW-1:0];
                end else begin
                    n_chk = 1'b0;
                end
                if (r_chk && deg_rdata != '0) begin
                    node_ctl.deg_we = 1'b1;
                    node_ctl.lab_we = 1'b1;
                    n_node_total    = r_node_total + CW'(1);
                end
                if (r_scan == CW'(MAX_NODES) && r_chk) begin
                    n_state = S_FIN_END;
                end
            end
            S_FIN_END: begin
                n_res            = '0;
                n_res.kind       = KIND_TOTALS;
                n_res.first_node = NODE_W'(r_node_total);
                n_res.kept_edges = KEPT_W'(r_edge_total);
                n_drain_ptr      = '0;
                n_draining       = (r_edge_total != '0);
                n_state          = S_EMIT;
            end
            S_DR_E: begin
                node_ctl.lab_re = 1'b1;
                n_state         = S_DR_L;
            end
            S_DR_L: begin
                n_res             = '0;
                n_res.kind        = KIND_EDGE;
                n_res.first_node  = NODE_W'(lab_lo) + NODE_W'(1);
                n_res.second_node = NODE_W'(lab_hi) + NODE_W'(1);
                n_res.edge_weight = edge_rdata[WEIGHT_W-1:0];
                n_res.kept_edges  = KEPT_W'(r_edge_total);
                n_res.last_edge   = drain_last;
                n_res.error_code  = ERR_NONE;
                n_drain_ptr       = r_drain_ptr + EW'(1);
                if (drain_last) begin
                    n_edge_total = '0;
                    n_drain_ptr  = '0;
                    n_draining   = 1'b0;
                end
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLR;
            r_scan       <= '0;
            r_chk        <= 1'b0;
            r_node_total <= '0;
            r_edge_total <= '0;
            r_drain_ptr  <= '0;
            r_draining   <= 1'b0;
            r_node_count <= NODE_W'(1024);
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_scan       <= n_scan;
            r_chk        <= n_chk;
            r_node_total <= n_node_total;
            r_edge_total <= n_edge_total;
            r_drain_ptr  <= n_drain_ptr;
            r_draining   <= n_draining;
            r_node_count <= n_node_count;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_chk_addr <= n_chk_addr;
        r_src_idx  <= n_src_idx;
        r_dst_idx  <= n_dst_idx;
        r_deg_fwd  <= n_deg_fwd;
        r_res      <= n_res;
        r_out      <= n_out;
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.kind        = r_out.kind;
    assign o_out.first_node  = r_out.first_node;
    assign o_out.second_node = r_out.second_node;
    assign o_out.edge_weight = r_out.edge_weight;
    assign o_out.kept_edges  = r_out.kept_edges;
    assign o_out.last_edge   = r_out.last_edge;
    assign o_out.error_code  = r_out.error_code;

    a_ptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_draining |-> (r_drain_ptr < r_edge_total))
        else $error("drain pointer past stored edges");

    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_edge_total <= EW'(MAX_EDGES))
        else $error("edge count above store depth");

    a_load_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_draining |-> (r_drain_ptr == '0))
        else $error("drain pointer not cleared while loading");

    a_drain_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in.valid && i_in.mode == MODE_DRAIN && r_draining)
        |=> (r_state == S_DR_E) ##1 (r_state == S_DR_L))
        else $error("drain transaction did not walk edge and label reads");

    a_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && out_free) |=> (r_out_valid && r_state == S_IDLE))
        else $error("pending result not moved to output register");

endmodule

/* dv/testbench.sv */
module testbench;
    import gic_pkg::*;

    localparam int NODES = 1024;
    localparam int LINKS = 4096;
    localparam int NODE_AW = $clog2(NODES);
    localparam int RUN_LIMIT = 12_000_000;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0]          mode;
        logic [NODE_W-1:0]          src_node;
        logic [NODE_W-1:0]          dst_node;
        logic signed [WEIGHT_W-1:0] weight;
    } t_item;

    class compactor_scoreboard;
        logic [NODE_W-1:0]          node_limit;
        logic [DEG_W-1:0]           degree [NODES];
        logic [NODE_W-1:0]          label [NODES];
        logic [NODE_AW-1:0]         link_a [LINKS];
        logic [NODE_AW-1:0]         link_b [LINKS];
        logic signed [WEIGHT_W-1:0] link_wt [LINKS];
        int                         link_count;
        int                         drain_idx;
        bit                         draining;
        t_result                    results_due [$];
        int                         errors;

        function new();
            node_limit = NODE_W'(NODES);
            foreach (degree[k]) degree[k] = '0;
            link_count = 0;
            drain_idx  = 0;
            draining   = 1'b0;
            errors     = 0;
        endfunction

        function void set_node_count(input logic [NODE_W-1:0] v);
            node_limit = v;
        endfunction

        function int node_span();
            return (node_limit > NODES) ? NODES : int'(node_limit);
        endfunction

        function void push_result(input logic [KIND_W-1:0] kind,
                                  input logic [NODE_W-1:0] first, second,
                                  input logic [WEIGHT_W-1:0] wt,
                                  input logic last,
                                  input logic [ERR_W-1:0] err);
            t_result r;
            r.kind        = kind;
            r.first_node  = first;
            r.second_node = second;
            r.edge_weight = wt;
            r.kept_edges  = KEPT_W'(link_count);
            r.last_edge   = last;
            r.error_code  = err;
            results_due = {results_due, r};
        endfunction

        // returns 1 when the transaction has an effect on the block
        function bit note(input t_item it);
            int                 n;
            int                 kept;
            logic [NODE_W-1:0]  x, y, t;
            logic [NODE_AW-1:0] sa, da;
            bit                 fin;
            n = node_span();
            case (it.mode)
                MODE_LOAD: begin
                    if (draining || it.weight == 0) return 1'b0;
                    if (it.src_node < 1 || it.src_node > n ||
                        it.dst_node < 1 || it.dst_node > n) begin
                        push_result(KIND_REJECT, '0, '0, '0, 1'b0, ERR_RANGE);
                        return 1'b1;
                    end
                    if (link_count >= LINKS) begin
                        push_result(KIND_REJECT, '0, '0, '0, 1'b0, ERR_FULL);
                        return 1'b1;
                    end
                    sa = NODE_AW'(it.src_node - 1'b1);
                    da = NODE_AW'(it.dst_node - 1'b1);
                    link_a[link_count]  = sa;
                    link_b[link_count]  = da;
                    link_wt[link_count] = it.weight;
                    link_count++;
                    if (degree[sa] != DEG_MAX)
                        degree[sa]++;
                    if (degree[da] != DEG_MAX)
                        degree[da]++;
                    return 1'b1;
                end
                MODE_FINISH: begin
                    if (draining) return 1'b0;
                    kept = 0;
                    for (int k = 0; k < NODES; k++) begin
                        if (degree[k] != 0) begin
                            label[k]  = NODE_W'(kept);
                            kept++;
                            degree[k] = '0;
                        end
                    end
                    push_result(KIND_TOTALS, NODE_W'(kept), '0, '0, 1'b0, ERR_NONE);
                    drain_idx = 0;
                    draining  = (link_count != 0);
                    return 1'b1;
                end
                MODE_DRAIN: begin
                    if (!draining || drain_idx >= link_count) return 1'b0;
                    x = label[link_a[drain_idx]];
                    y = label[link_b[drain_idx]];
                    if (x > y) begin
                        t = x;
                        x = y;
                        y = t;
                    end
                    fin = (drain_idx + 1 == link_count);
                    push_result(KIND_EDGE, x + 1'b1, y + 1'b1, link_wt[drain_idx], fin,
                                ERR_NONE);
                    drain_idx++;
                    if (fin) begin
                        link_count = 0;
                        drain_idx  = 0;
                        draining   = 1'b0;
                    end
                    return 1'b1;
                end
                default: return 1'b0;
            endcase
            return 1'b0;
        endfunction

        function void field_check(input string name, input logic [WEIGHT_W-1:0] want, got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            end
        endfunction

        function void check(input t_result got);
            t_result want;
            if (results_due.size() == 0) begin
                errors++;
                $display("%0t: result expected none actual %0h", $time, got);
                return;
            end
            want = results_due.pop_front();
            field_check("kind", want.kind, got.kind);
            field_check("first_node", want.first_node, got.first_node);
            field_check("second_node", want.second_node, got.second_node);
            field_check("edge_weight", want.edge_weight, got.edge_weight);
            field_check("kept_edges", want.kept_edges, got.kept_edges);
            field_check("last_edge", want.last_edge, got.last_edge);
            field_check("error_code", want.error_code, got.error_code);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    gic_cfg_if cfg_if ();
    gic_in_if  in_if ();
    gic_out_if out_if ();

    graph_isolated_node_compactor #(
        .MAX_NODES(NODES),
        .MAX_EDGES(LINKS)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (cfg_if),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    compactor_scoreboard sb;
    int src_idle_pct;
    int sink_stall_pct;
    int effective_items;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #(RUN_LIMIT);
        $display("graph_isolated_node_compactor: mismatch");
        $finish;
    end

    initial begin
        t_result got;
        out_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_if.valid && out_if.ready) begin
                got.kind        = out_if.kind;
                got.first_node  = out_if.first_node;
                got.second_node = out_if.second_node;
                got.edge_weight = out_if.edge_weight;
                got.kept_edges  = out_if.kept_edges;
                got.last_edge   = out_if.last_edge;
                got.error_code  = out_if.error_code;
                sb.check(got);
            end
            out_if.ready <= (int'($urandom_range(99)) >= sink_stall_pct);
        end
    end

    function automatic logic [WEIGHT_W-1:0] nz_weight();
        logic [WEIGHT_W-1:0] w;
        w = $urandom();
        return (w == 0) ? WEIGHT_W'(1) : w;
    endfunction

    task automatic send_item(input logic [MODE_W-1:0] mode, input int src, dst,
                             input logic [WEIGHT_W-1:0] wt);
        t_item it;
        it.mode     = mode;
        it.src_node = NODE_W'(src);
        it.dst_node = NODE_W'(dst);
        it.weight   = wt;
        while (int'($urandom_range(99)) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid    <= 1'b1;
        in_if.mode     <= it.mode;
        in_if.src_node <= it.src_node;
        in_if.dst_node <= it.dst_node;
        in_if.weight   <= it.weight;
        do @(posedge i_clk); while (!in_if.ready);
        if (sb.note(it)) effective_items++;
    endtask

    // wait for every pending result, then let any load in flight finish
    task automatic settle();
        in_if.valid <= 1'b0;
        while (sb.results_due.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_node_count(input logic [NODE_W-1:0] v);
        settle();
        cfg_if.valid      <= 1'b1;
        cfg_if.node_count <= v;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        sb.set_node_count(v);
    endtask

    task automatic run_graph();
        int n;
        int k;
        int r;
        n = sb.node_span();
        k = ($urandom_range(99) < 10) ? $urandom_range(120, 1) : $urandom_range(14, 1);
        repeat (k) begin
            r = $urandom_range(99);
            if (r < 74)
                send_item(MODE_LOAD, $urandom_range(n, 1), $urandom_range(n, 1), nz_weight());
            else if (r < 82)
                send_item(MODE_LOAD, $urandom_range(n, 1), $urandom_range(n, 1), '0);
            else if (r < 90)
                send_item(MODE_LOAD, $urandom_range(2047, 0), $urandom_range(2047, 0),
                          nz_weight());
            else if (r < 95)
                send_item(MODE_DRAIN, $urandom_range(2047, 0), $urandom_range(2047, 0),
                          $urandom());
            else
                send_item(MODE_UNUSED, $urandom_range(2047, 0), $urandom_range(2047, 0),
                          $urandom());
        end
        send_item(MODE_FINISH, $urandom_range(2047, 0), $urandom_range(2047, 0), $urandom());
        while (sb.draining) begin
            r = $urandom_range(99);
            if (r < 88)
                send_item(MODE_DRAIN, $urandom_range(2047, 0), $urandom_range(2047, 0),
                          $urandom());
            else if (r < 93)
                send_item(MODE_LOAD, $urandom_range(n, 1), $urandom_range(n, 1), nz_weight());
            else if (r < 97)
                send_item(MODE_FINISH, $urandom_range(2047, 0), $urandom_range(2047, 0),
                          $urandom());
            else
                send_item(MODE_UNUSED, $urandom_range(2047, 0), $urandom_range(2047, 0),
                          $urandom());
        end
    endtask

    initial begin
        logic [NODE_W-1:0] cfg_plan [8];
        int                target;
        i_rst_n           = 1'b0;
        in_if.valid       = 1'b0;
        in_if.mode        = MODE_LOAD;
        in_if.src_node    = '0;
        in_if.dst_node    = '0;
        in_if.weight      = '0;
        cfg_if.valid      = 1'b0;
        cfg_if.node_count = '0;
        src_idle_pct      = 0;
        sink_stall_pct    = 0;
        effective_items   = 0;
        sb = new();
        cfg_plan = '{11'd1, 11'd1023, 11'd2, 11'd2047, 11'd7,
                     NODE_W'($urandom_range(NODES, 1)), 11'd1024,
                     NODE_W'($urandom_range(NODES, 1))};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed
        send_item(MODE_DRAIN, 0, 0, '0);
        send_item(MODE_FINISH, 0, 0, '0);
        send_item(MODE_LOAD, 1, NODES, 32'h7fff_ffff);
        send_item(MODE_LOAD, NODES, 1, 32'h8000_0000);
        send_item(MODE_LOAD, 5, 5, 32'hffff_ffff);
        send_item(MODE_LOAD, 3, 7, 32'h0000_0000);
        send_item(MODE_LOAD, 0, 5, 32'h0000_0001);
        send_item(MODE_LOAD, NODES + 1, 2, 32'h0001_0000);
        send_item(MODE_LOAD, 2, 2047, 32'h0000_0001);
        send_item(MODE_UNUSED, 2047, 2047, 32'hffff_ffff);
        send_item(MODE_FINISH, 2047, 0, '0);
        send_item(MODE_LOAD, 1, 1, 32'h0000_0001);
        send_item(MODE_FINISH, 0, 0, '0);
        repeat (3) send_item(MODE_DRAIN, 2047, 2047, 32'hffff_ffff);
        send_item(MODE_DRAIN, 0, 0, '0);
        // register lowered between loads of one graph
        send_item(MODE_LOAD, 1000, NODES, 32'hffff_0000);
        write_node_count(11'd3);
        send_item(MODE_LOAD, 1, 3, 32'h0000_8000);
        send_item(MODE_LOAD, 4, 1, 32'h0000_0001);
        send_item(MODE_LOAD, 1000, 1, 32'h0000_0001);
        send_item(MODE_FINISH, 0, 0, '0);
        repeat (2) send_item(MODE_DRAIN, 0, 0, '0);

        for (int ph = 0; ph < 4; ph++) begin
            settle();
            case (ph)
                0: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
                1: begin
                    src_idle_pct   = 88;
                    sink_stall_pct = 0;
                end
                2: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 88;
                end
                default: begin
                    src_idle_pct   = 30;
                    sink_stall_pct = 30;
                end
            endcase
            for (int sub = 0; sub < 2; sub++) begin
                write_node_count(cfg_plan[2 * ph + sub]);
                target = effective_items + 190;
                while (effective_items < target) run_graph();
            end
        end

        settle();
        if (sb.errors == 0 && sb.results_due.size() == 0)
            $display("graph_isolated_node_compactor: match");
        else
            $display("graph_isolated_node_compactor: mismatch");
        $finish;
    end

endmodule
